@@ rtl/rme_pkg.sv @@
`timescale 1ns / 1ps

package rme_pkg;

	// Width of every payload port and of the configuration data port
	localparam int FIELD_BITS = 32;
	// Default operand width of the exponentiation datapath
	localparam int RME_WORD_BITS = 32;
	// Width of the configuration register index
	localparam int CFG_INDEX_BITS = 2;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_MODULUS  = 2'd0,
		REG_PUB_EXP  = 2'd1,
		REG_PRIV_EXP = 2'd2
	} cfg_reg_t;

	localparam logic KIND_DECIPHER = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_RED_WAIT,
		ST_SQR_GO,
		ST_SQR_WAIT,
		ST_MUL_GO,
		ST_MUL_WAIT,
		ST_NEXT,
		ST_DONE
	} state_t;

	// Operand selection of the modular multiplier
	typedef enum logic [1:0] {
		SEL_RED,
		SEL_SQR,
		SEL_MUL
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     set_one;
		logic     mul_go;
		mul_sel_t sel;
		logic     wr_base;
		logic     wr_acc;
		logic     exp_next;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic exp_zero;
		logic exp_bit;
		logic last_bit;
	} status_t;

endpackage

@@ rtl/rme_mulmod.sv @@
`timescale 1ns / 1ps

// Interleaved modular multiplier: res = a * b mod m, one bit of a per cycle,
// MSB first. Requires b < m; a may take any value. m may be 2^W.
module rme_mulmod import rme_pkg::*; #(
	parameter int WORD_BITS = RME_WORD_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  logic [WORD_BITS-1:0] a,
	input  logic [WORD_BITS-1:0] b,
	input  logic [WORD_BITS:0]   m,
	output logic                 done,
	output logic [WORD_BITS-1:0] res
);

	localparam int XW = WORD_BITS + 3;
	localparam int CW = $clog2(WORD_BITS);

	logic                 busy_q;
	logic                 done_q;
	logic [CW-1:0]        cnt_q;
	logic [WORD_BITS-1:0] a_q;
	logic [WORD_BITS-1:0] b_q;
	logic [WORD_BITS-1:0] r_q;
	logic [XW-1:0]        bm1_q;
	logic [XW-1:0]        bm2_q;

	logic [XW-1:0] two_r;
	logic [XW-1:0] t1;
	logic [XW-1:0] u0;
	logic [XW-1:0] u1;
	logic [XW-1:0] u2;
	logic [XW-1:0] r_next;

	// 2r + bit*b is below 3m: pick the smallest non-negative candidate
	always_comb begin
		two_r = {2'b00, r_q, 1'b0};
		t1    = two_r - XW'(m);
		u0    = two_r + XW'(b_q);
		u1    = two_r + bm1_q;
		u2    = two_r + bm2_q;
		if (a_q[WORD_BITS-1]) begin
			if (!u2[XW-1]) begin
				r_next = u2;
			end else if (!u1[XW-1]) begin
				r_next = u1;
			end else begin
				r_next = u0;
			end
		end else begin
			r_next = t1[XW-1] ? two_r : t1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(WORD_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			a_q   <= a;
			b_q   <= b;
			r_q   <= '0;
			bm1_q <= XW'(b) - XW'(m);
			bm2_q <= XW'(b) - XW'({m, 1'b0});
		end else if (busy_q) begin
			a_q <= {a_q[WORD_BITS-2:0], 1'b0};
			r_q <= r_next[WORD_BITS-1:0];
		end
	end

	assign done = done_q;
	assign res  = r_q;

endmodule

@@ rtl/rme_datapath.sv @@
`timescale 1ns / 1ps

module rme_datapath import rme_pkg::*; #(
	parameter int WORD_BITS = RME_WORD_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmd_t                      cmd,
	output status_t                   sts,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [FIELD_BITS-1:0]     cfg_data,
	input  logic                      kind,
	input  logic [FIELD_BITS-1:0]     value_in,
	output logic [FIELD_BITS-1:0]     value_out
);

	localparam int CW = $clog2(WORD_BITS);

	logic [WORD_BITS-1:0] modulus_q;
	logic [WORD_BITS-1:0] pub_exp_q;
	logic [WORD_BITS-1:0] priv_exp_q;

	logic [WORD_BITS-1:0] val_q;
	logic [WORD_BITS-1:0] base_q;
	logic [WORD_BITS-1:0] acc_q;
	logic [WORD_BITS-1:0] exp_q;
	logic [CW-1:0]        cnt_q;

	logic [WORD_BITS:0]   m_eff;
	logic [WORD_BITS-1:0] one_m;
	logic [WORD_BITS-1:0] mul_a;
	logic [WORD_BITS-1:0] mul_b;
	logic                 mul_done;
	logic [WORD_BITS-1:0] mul_res;

	// Zero modulus stands for 2^W, so the products wrap
	assign m_eff = {(modulus_q == '0), modulus_q};
	assign one_m = (m_eff == (WORD_BITS+1)'(1)) ? '0 : WORD_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= WORD_BITS'(2);
			pub_exp_q  <= '0;
			priv_exp_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_MODULUS:  modulus_q  <= cfg_data[WORD_BITS-1:0];
				REG_PUB_EXP:  pub_exp_q  <= cfg_data[WORD_BITS-1:0];
				REG_PRIV_EXP: priv_exp_q <= cfg_data[WORD_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (cmd.sel)
			SEL_RED: begin
				mul_a = val_q;
				mul_b = one_m;
			end
			SEL_SQR: begin
				mul_a = acc_q;
				mul_b = acc_q;
			end
			SEL_MUL: begin
				mul_a = acc_q;
				mul_b = base_q;
			end
			default: begin
				mul_a = acc_q;
				mul_b = acc_q;
			end
		endcase
	end

	rme_mulmod #(
		.WORD_BITS(WORD_BITS)
	) u_mulmod (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (cmd.mul_go),
		.a     (mul_a),
		.b     (mul_b),
		.m     (m_eff),
		.done  (mul_done),
		.res   (mul_res)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q <= value_in[WORD_BITS-1:0];
			exp_q <= (kind == KIND_DECIPHER) ? priv_exp_q : pub_exp_q;
			acc_q <= one_m;
			cnt_q <= '0;
		end else begin
			if (cmd.set_one) begin
				acc_q <= WORD_BITS'(1);
			end else if (cmd.wr_acc) begin
				acc_q <= mul_res;
			end
			if (cmd.wr_base) begin
				base_q <= mul_res;
			end
			if (cmd.exp_next) begin
				exp_q <= {exp_q[WORD_BITS-2:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		sts.mul_done = mul_done;
		sts.exp_zero = (exp_q == '0);
		sts.exp_bit  = exp_q[WORD_BITS-1];
		sts.last_bit = (cnt_q == CW'(WORD_BITS - 1));
	end

	assign value_out = FIELD_BITS'(acc_q);

endmodule

@@ rtl/rme_ctrl.sv @@
`timescale 1ns / 1ps

module rme_ctrl import rme_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	output logic    done,
	output cmd_t    cmd,
	input  status_t sts
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (start) state_d = ST_CHECK;
			ST_CHECK:    state_d = sts.exp_zero ? ST_DONE : ST_RED_WAIT;
			ST_RED_WAIT: if (sts.mul_done) state_d = ST_SQR_GO;
			ST_SQR_GO:   state_d = ST_SQR_WAIT;
			ST_SQR_WAIT: begin
				if (sts.mul_done) begin
					state_d = sts.exp_bit ? ST_MUL_GO : ST_NEXT;
				end
			end
			ST_MUL_GO:   state_d = ST_MUL_WAIT;
			ST_MUL_WAIT: if (sts.mul_done) state_d = ST_NEXT;
			ST_NEXT:     state_d = sts.last_bit ? ST_DONE : ST_SQR_GO;
			ST_DONE:     state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.sel  = SEL_SQR;
		busy     = (state_q != ST_IDLE);
		done     = 1'b0;
		case (state_q)
			ST_IDLE: cmd.load = start;
			ST_CHECK: begin
				cmd.set_one = sts.exp_zero;
				cmd.mul_go  = !sts.exp_zero;
				cmd.sel     = SEL_RED;
			end
			ST_RED_WAIT: begin
				cmd.sel     = SEL_RED;
				cmd.wr_base = sts.mul_done;
			end
			ST_SQR_GO: cmd.mul_go = 1'b1;
			ST_SQR_WAIT: cmd.wr_acc = sts.mul_done;
			ST_MUL_GO: begin
				cmd.mul_go = 1'b1;
				cmd.sel    = SEL_MUL;
			end
			ST_MUL_WAIT: begin
				cmd.sel    = SEL_MUL;
				cmd.wr_acc = sts.mul_done;
			end
			ST_NEXT: cmd.exp_next = 1'b1;
			ST_DONE: done = 1'b1;
			default: begin
			end
		endcase
	end

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not raise busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("done not a single pulse followed by idle");

	a_go_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_go |=> !sts.mul_done)
		else $error("multiplier finished one cycle after launch");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy && !cmd.mul_go)
		else $error("done outside an active request");

endmodule

@@ rtl/rsa_modular_exponentiation_unit.sv @@
`timescale 1ns / 1ps
// A zero exponent goes from accept through CHECK straight to DONE;
// otherwise a request runs one base reduction, then for each of the W
// exponent bits (W = WORD_BITS) a square, plus a multiply for each set bit.
// Throughput: one request at a time; busy stays high until the done strobe.
// The receiver cannot stall: value_out holds from the done cycle until a new request is accepted.
// Reset (arst_n low, asynchronous): idle, modulus 2, both exponents 0.

module rsa_modular_exponentiation_unit import rme_pkg::*; #(
	parameter int WORD_BITS = RME_WORD_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// Request channel
	input  logic                      start,
	output logic                      busy,
	input  logic                      kind,
	input  logic [FIELD_BITS-1:0]     value_in,
	// Result strobe
	output logic                      done,
	output logic [FIELD_BITS-1:0]     value_out,
	// Configuration write channel
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [FIELD_BITS-1:0]     cfg_data
);

	// Command and status between the controller and the datapath
	cmd_t    cmd;
	status_t sts;

	// Registers take a write in any cycle; software must write them only
	// while no request is in flight, which the block does not enforce.
	assign cfg_ready = 1'b1;

	// Controller: unless the exponent is zero, sequences reduce base, then per
	// exponent bit (MSB first) square and, where the bit is set, multiply by the base.
	rme_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.done  (done),
		.cmd   (cmd),
		.sts   (sts)
	);

	// Datapath: configuration registers, accumulator, base, exponent
	// shifter and the shared iterative modular multiplier.
	rme_datapath #(
		.WORD_BITS(WORD_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.cfg_we   (cfg_valid & cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.kind     (kind),
		.value_in (value_in),
		.value_out(value_out)
	);

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import rme_pkg::*;

	// Operand width of the block as instantiated (default parameter)
	localparam int W = RME_WORD_BITS;
	localparam logic [63:0] WORD_MASK = (64'd1 << W) - 64'd1;

	// Encipher is the opposite of the package's decipher code
	localparam logic KIND_ENCIPHER = ~KIND_DECIPHER;
	// Index past the end of the register list: the block must drop the write
	localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

	// Give up when no handshake of any kind comes within this limit; it lies
	// well above the worst request and the longest sender gap
	localparam int WATCHDOG_LIMIT = 20000;
	// Quiet cycles after the last result, to catch a stray strobe
	localparam int DRAIN_CYCLES = 2300;
	localparam int RANDOM_ITEMS = 250;
	localparam int PLAN_ROWS = 36;

	// Directed plan: a register write, a request with a hand-worked answer,
	// or a request whose answer comes from the predictor
	typedef enum logic [1:0] {
		ROW_WRITE,
		ROW_GOLDEN,
		ROW_PREDICT
	} row_kind_t;

	typedef struct packed {
		row_kind_t                 act;
		logic [CFG_INDEX_BITS-1:0] index;
		logic                      op;
		logic [FIELD_BITS-1:0]     word;
		logic [FIELD_BITS-1:0]     golden;
	} plan_row_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic                      kind;
	logic [FIELD_BITS-1:0]     value_in;
	logic                      done;
	logic [FIELD_BITS-1:0]     value_out;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [FIELD_BITS-1:0]     cfg_data;

	// Side-band for the monitor: hand-worked answer of the request on the bus
	logic                      req_has_golden;
	logic [FIELD_BITS-1:0]     req_golden;

	// Predictor's copy of the configuration, reset values of the block
	logic [FIELD_BITS-1:0]     mirror_modulus  = 2;
	logic [FIELD_BITS-1:0]     mirror_pub_exp  = 0;
	logic [FIELD_BITS-1:0]     mirror_priv_exp = 0;

	logic [FIELD_BITS-1:0]     expected_powers [$];
	int                        requests_in_flight = 0;
	int                        mismatch_count = 0;
	int                        quiet_cycles = 0;

	// Stimulus-side state
	logic [FIELD_BITS-1:0]     cur_modulus = 2;
	bit                        no_idle = 1'b0;
	plan_row_t                 plan [PLAN_ROWS];
	logic [CFG_INDEX_BITS-1:0] reg_choices [4] =
		'{REG_MODULUS, REG_PUB_EXP, REG_PRIV_EXP, REG_UNUSED};

	always #5 clk = ~clk;

	rsa_modular_exponentiation_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.kind      (kind),
		.value_in  (value_in),
		.done      (done),
		.value_out (value_out),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// ------------------------------------------------------------------
	// Predictor: left-to-right square-and-multiply at W bits; a zero
	// modulus means plain wrap at 2^W
	// ------------------------------------------------------------------
	function automatic logic [63:0] wrap_reduce(input logic [63:0] x, input logic [63:0] m);
		return (m == 64'd0) ? (x & WORD_MASK) : (x % m);
	endfunction

	function automatic logic [FIELD_BITS-1:0] predict_power(input logic [63:0] base,
			input logic [63:0] expo, input logic [63:0] m);
		logic [63:0] acc;
		logic [63:0] b;
		logic [63:0] e;
		logic [63:0] mm;
		e  = expo & WORD_MASK;
		mm = m & WORD_MASK;
		// zero exponent: one, whatever the value and the modulus
		if (e == 64'd0)
			return 1;
		acc = 64'd1;
		// reduce the value first so values at or above the modulus alias
		b = wrap_reduce(base & WORD_MASK, mm);
		for (int pos = W - 1; pos >= 0; pos--) begin
			acc = wrap_reduce(acc * acc, mm);
			if (e[pos])
				acc = wrap_reduce(acc * b, mm);
		end
		return acc[FIELD_BITS-1:0];
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	// ------------------------------------------------------------------
	// Monitor: follow config writes, predict on each accepted request,
	// check each done strobe against the oldest prediction
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		logic [FIELD_BITS-1:0] want;
		logic                  accepted;
		if (arst_n) begin
			accepted = start && !busy;
			// Check the result first: it belongs to an earlier request
			if (done) begin
				if (expected_powers.size() == 0) begin
					report_mismatch($sformatf("value_out %h with no request in flight",
						value_out));
				end else begin
					want = expected_powers.pop_front();
					if (value_out !== want)
						report_mismatch($sformatf("value_out %h, expected %h",
							value_out, want));
				end
			end
			// Track the register file; drop writes to unused indexes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MODULUS:  mirror_modulus  = cfg_data & WORD_MASK[FIELD_BITS-1:0];
					REG_PUB_EXP:  mirror_pub_exp  = cfg_data & WORD_MASK[FIELD_BITS-1:0];
					REG_PRIV_EXP: mirror_priv_exp = cfg_data & WORD_MASK[FIELD_BITS-1:0];
					default: ;
				endcase
			end
			if (accepted) begin
				if (req_has_golden)
					expected_powers.push_back(req_golden);
				else
					expected_powers.push_back(predict_power(value_in,
						(kind == KIND_DECIPHER) ? mirror_priv_exp : mirror_pub_exp,
						mirror_modulus));
			end
			// Publish the count by NBA so the stimulus reads a settled value
			requests_in_flight <= requests_in_flight + (accepted ? 1 : 0) - (done ? 1 : 0);
		end
	end

	// Watchdog: end the run if nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[%0t] watchdog: no handshake for %0d cycles", $time, quiet_cycles);
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	// Mostly back-to-back, some short gaps, a few long enough to land
	// anywhere inside a request's run
	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 6);
		if (r < 97)
			return $urandom_range(7, 300);
		return $urandom_range(301, 2600);
	endfunction

	function automatic logic [FIELD_BITS-1:0] pick_modulus();
		case ($urandom_range(0, 19))
			0:       return $urandom_range(0, 1);    // out of range: wrap or one
			1:       return 32'hFFFF_FFFF;
			2:       return 32'd2;
			3, 4, 5: return $urandom_range(3, 255);
			default: return $urandom_range(32'hFFFF_FFFF, 2);
		endcase
	endfunction

	function automatic logic [FIELD_BITS-1:0] pick_exponent();
		case ($urandom_range(0, 15))
			0:       return 32'd0;
			1:       return 32'd1;
			2:       return 32'h0001_0001;
			3:       return 32'hFFFF_FFFF;
			4:       return $urandom_range(2, 31);
			default: return $urandom;
		endcase
	endfunction

	// Bias operands toward the edges around the current modulus
	function automatic logic [FIELD_BITS-1:0] pick_operand(input logic [FIELD_BITS-1:0] m);
		case ($urandom_range(0, 11))
			0:       return 32'd0;
			1:       return 32'd1;
			2:       return 32'hFFFF_FFFF;
			3:       return m;
			4:       return m - 32'd1;
			5:       return $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	// Drop both valids, then hold until every request in flight has
	// come back. Step one edge first so the last accept is counted.
	task automatic wait_drained();
		start     <= 1'b0;
		cfg_valid <= 1'b0;
		@(posedge clk);
		while (requests_in_flight != 0)
			@(posedge clk);
	endtask

	// Write one register with the block idle
	task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [FIELD_BITS-1:0] data);
		wait_drained();
		repeat (pick_gap()) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_MODULUS)
			cur_modulus = data;
	endtask

	// Issue one request and hold it until accepted. With a zero gap keep
	// start high straight through into the new request.
	task automatic issue_request(input logic op, input logic [FIELD_BITS-1:0] operand,
			input logic has_golden, input logic [FIELD_BITS-1:0] golden);
		int gap;
		gap = pick_gap();
		cfg_valid <= 1'b0;
		if (gap > 0) begin
			// idle the request port with junk on the payload
			start    <= 1'b0;
			kind     <= $urandom_range(0, 1);
			value_in <= $urandom;
			repeat (gap) @(posedge clk);
		end
		start          <= 1'b1;
		kind           <= op;
		value_in       <= operand;
		req_has_golden <= has_golden;
		req_golden     <= golden;
		do @(posedge clk); while (busy);
	endtask

	function automatic plan_row_t write_row(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [FIELD_BITS-1:0] data);
		return '{act: ROW_WRITE, index: idx, op: 1'b0, word: data, golden: '0};
	endfunction

	function automatic plan_row_t golden_row(input logic op,
			input logic [FIELD_BITS-1:0] operand, input logic [FIELD_BITS-1:0] golden);
		return '{act: ROW_GOLDEN, index: REG_UNUSED, op: op, word: operand, golden: golden};
	endfunction

	function automatic plan_row_t predicted_row(input logic op,
			input logic [FIELD_BITS-1:0] operand);
		return '{act: ROW_PREDICT, index: REG_UNUSED, op: op, word: operand, golden: '0};
	endfunction

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int                        n_random;
		int                        phase_len;
		int                        n_writes;
		logic [CFG_INDEX_BITS-1:0] idx;
		logic [FIELD_BITS-1:0]     data;

		// Known values on every input before the first edge
		arst_n         = 1'b0;
		start          = 1'b0;
		kind           = KIND_ENCIPHER;
		value_in       = '0;
		cfg_valid      = 1'b0;
		cfg_index      = REG_MODULUS;
		cfg_data       = '0;
		req_has_golden = 1'b0;
		req_golden     = '0;

		plan = '{
			// reset state: modulus 2, both exponents zero -> always one
			golden_row(KIND_ENCIPHER, 32'h0000_0000, 32'd1),
			golden_row(KIND_ENCIPHER, 32'hFFFF_FFFF, 32'd1),
			golden_row(KIND_DECIPHER, 32'h1234_5678, 32'd1),
			// small modulus; the unused index must not disturb anything
			write_row(REG_MODULUS,  32'd1000),
			write_row(REG_PUB_EXP,  32'd1),
			write_row(REG_PRIV_EXP, 32'd2),
			write_row(REG_UNUSED,   32'd0),
			golden_row(KIND_ENCIPHER, 32'd12345, 32'd345),
			golden_row(KIND_DECIPHER, 32'd1001,  32'd1),
			golden_row(KIND_DECIPHER, 32'd0,     32'd0),
			predicted_row(KIND_DECIPHER, 32'd999),
			// zero modulus: plain wrap at the word width
			write_row(REG_MODULUS,  32'd0),
			write_row(REG_PUB_EXP,  32'hFFFF_FFFF),
			write_row(REG_PRIV_EXP, 32'd2),
			golden_row(KIND_DECIPHER, 32'hFFFF_FFFF, 32'd1),
			golden_row(KIND_DECIPHER, 32'h0001_0000, 32'd0),
			golden_row(KIND_ENCIPHER, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
			predicted_row(KIND_ENCIPHER, 32'd3),
			// modulus one: zero unless the exponent is zero
			write_row(REG_MODULUS,  32'd1),
			golden_row(KIND_ENCIPHER, 32'd5, 32'd0),
			write_row(REG_PRIV_EXP, 32'd0),
			golden_row(KIND_DECIPHER, 32'd5, 32'd1),
			// all-ones modulus and public exponent
			write_row(REG_MODULUS,  32'hFFFF_FFFF),
			write_row(REG_PUB_EXP,  32'hFFFF_FFFF),
			write_row(REG_PRIV_EXP, 32'hFFFF_FFFE),
			golden_row(KIND_ENCIPHER, 32'hFFFF_FFFF, 32'd0),
			golden_row(KIND_ENCIPHER, 32'hFFFF_FFFE, 32'hFFFF_FFFE),
			golden_row(KIND_DECIPHER, 32'hFFFF_FFFE, 32'd1),
			predicted_row(KIND_ENCIPHER, 32'h8000_0000),
			golden_row(KIND_DECIPHER, 32'd0, 32'd0),
			// largest 32-bit prime, usual public exponent
			write_row(REG_MODULUS,  32'hFFFF_FFFB),
			write_row(REG_PUB_EXP,  32'h0001_0001),
			write_row(REG_PRIV_EXP, 32'hDEAD_BEEF),
			predicted_row(KIND_ENCIPHER, 32'd2),
			predicted_row(KIND_DECIPHER, 32'hA5A5_A5A5),
			predicted_row(KIND_ENCIPHER, 32'hFFFF_FFFF)
		};

		// Hold reset from time zero, release on a rising edge
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Walk the directed plan
		foreach (plan[i]) begin
			case (plan[i].act)
				ROW_WRITE:  write_register(plan[i].index, plan[i].word);
				ROW_GOLDEN: issue_request(plan[i].op, plan[i].word, 1'b1, plan[i].golden);
				default:    issue_request(plan[i].op, plan[i].word, 1'b0, '0);
			endcase
		end

		// Random phases: reprogram some registers, then a burst of requests
		n_random = 0;
		while (n_random < RANDOM_ITEMS) begin
			// some phases run with no idling at all
			no_idle  = ($urandom_range(0, 3) == 0);
			n_writes = $urandom_range(1, 4);
			repeat (n_writes) begin
				idx = reg_choices[$urandom_range(0, 3)];
				case (idx)
					REG_MODULUS:              data = pick_modulus();
					REG_PUB_EXP, REG_PRIV_EXP: data = pick_exponent();
					default:                  data = $urandom;
				endcase
				write_register(idx, data);
			end
			phase_len = $urandom_range(8, 40);
			repeat (phase_len) begin
				issue_request($urandom_range(0, 1) ? KIND_DECIPHER : KIND_ENCIPHER,
					pick_operand(cur_modulus), 1'b0, '0);
				n_random++;
			end
		end

		// Drain, then watch for stray strobes a full request's worth
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
